FILE: rtl/rdhs_pkg.sv
package rdhs_pkg;

	localparam int unsigned MAX_DATAGRAM_DEF = 4096;
	localparam logic [7:0]  MAGIC_RESET      = 8'h41;

	// arithmetic width for the classification, covers a shifted extension word
	localparam int unsigned CALC_W = 20;

	localparam int unsigned IDX_MAGIC  = 0;
	localparam int unsigned IDX_LEN_HI = 1;
	localparam int unsigned IDX_LEN_LO = 2;
	localparam int unsigned IDX_FLAGS  = 3;
	localparam int unsigned IDX_SEQ_HI = 5;
	localparam int unsigned IDX_SEQ_LO = 6;
	localparam int unsigned IDX_EXT_MIN = 4;

	localparam int unsigned RTP_HDR_BASE = 12;
	localparam int unsigned EXT_HI_OFS   = 5;
	localparam int unsigned EXT_LO_OFS   = 6;
	localparam int unsigned FRAME_HDR    = 3;
	localparam int unsigned EXT_HDR      = 4;
	localparam logic [1:0]  RTP_VERSION  = 2'd2;

	typedef enum logic [1:0] {
		KIND_TEXT = 2'd0,
		KIND_RTP  = 2'd1,
		KIND_RAW  = 2'd2,
		KIND_DROP = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]  first;
		logic [15:0] len;
		logic [7:0]  flags;
		logic [15:0] seq;
		logic [15:0] ext;
		logic [7:0]  pad;
	} hdr_fields_t;

	localparam hdr_fields_t HDR_CLEAR = '0;

endpackage

FILE: rtl/rdhs_capture.sv
module rdhs_capture
	import rdhs_pkg::*;
#(
	parameter int unsigned MAX_DATAGRAM = MAX_DATAGRAM_DEF,
	localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             s_tlast,
	input  logic             res_ready,
	output logic             valid_s2,
	output hdr_fields_t      fields_s2,
	output logic [POS_W-1:0] count_s2
);

	localparam int unsigned CW = ((POS_W > 17) ? POS_W : 17) + 1;

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic [POS_W-1:0] pos_q;
	hdr_fields_t      fld_q;

	logic             s2_free;
	logic             s1_move;
	logic             in_range;
	logic [CW-1:0]    idx_w;
	logic [CW-1:0]    pad_idx;
	logic [CW-1:0]    hdr_w;
	logic [6:0]       hdr7;
	hdr_fields_t      fld_nxt;
	logic [POS_W-1:0] pos_nxt;

	assign s2_free  = !valid_s2 || res_ready;
	assign s1_move  = valid_s1 && (!last_s1 || s2_free);
	assign s_tready = !valid_s1 || s1_move;

	always_comb begin
		in_range = pos_q < POS_W'(MAX_DATAGRAM);
		idx_w    = CW'(pos_q);
		pad_idx  = CW'(fld_q.len) + CW'(IDX_LEN_LO);
		hdr7     = 7'(RTP_HDR_BASE) + {1'b0, fld_q.flags[3:0], 2'b00};
		hdr_w    = CW'(hdr7);
		fld_nxt  = fld_q;
		pos_nxt  = pos_q;
		if (in_range) begin
			pos_nxt = pos_q + POS_W'(1);
			if (idx_w == CW'(IDX_MAGIC))  fld_nxt.first      = data_s1;
			if (idx_w == CW'(IDX_LEN_HI)) fld_nxt.len[15:8]  = data_s1;
			if (idx_w == CW'(IDX_LEN_LO)) fld_nxt.len[7:0]   = data_s1;
			if (idx_w == CW'(IDX_FLAGS))  fld_nxt.flags      = data_s1;
			if (idx_w == CW'(IDX_SEQ_HI)) fld_nxt.seq[15:8]  = data_s1;
			if (idx_w == CW'(IDX_SEQ_LO)) fld_nxt.seq[7:0]   = data_s1;
			if (idx_w >= CW'(IDX_FLAGS) && idx_w == pad_idx) fld_nxt.pad = data_s1;
			if (idx_w >= CW'(IDX_EXT_MIN)) begin
				if (idx_w == hdr_w + CW'(EXT_HI_OFS)) fld_nxt.ext[15:8] = data_s1;
				if (idx_w == hdr_w + CW'(EXT_LO_OFS)) fld_nxt.ext[7:0]  = data_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// per-datagram state, cleared after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fld_q <= HDR_CLEAR;
		end else if (s1_move) begin
			if (last_s1) begin
				pos_q <= '0;
				fld_q <= HDR_CLEAR;
			end else begin
				pos_q <= pos_nxt;
				fld_q <= fld_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			fields_s2 <= fld_nxt;
			count_s2  <= pos_nxt;
		end
	end

endmodule

FILE: rtl/rdhs_classify.sv
module rdhs_classify
	import rdhs_pkg::*;
#(
	parameter int unsigned MAX_DATAGRAM = MAX_DATAGRAM_DEF,
	localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [7:0]       cfg_wdata,
	input  logic             valid_s2,
	input  hdr_fields_t      fields_s2,
	input  logic [POS_W-1:0] count_s2,
	output logic             res_ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [55:0]      m_tdata,
	output logic [7:0]       m_tuser
);

	logic [7:0]        magic_q;
	logic              m_tvalid_q;
	logic [55:0]       m_tdata_q;
	logic [7:0]        m_tuser_q;

	logic [CALC_W-1:0] n_w;
	logic [CALC_W-1:0] len_w;
	logic [CALC_W-1:0] pad_w;
	logic [CALC_W-1:0] ext_w;
	logic [CALC_W-1:0] hdr0;
	logic [CALC_W-1:0] hdr1;
	logic [CALC_W-1:0] plen1;
	logic [CALC_W-1:0] plen2;
	logic [CALC_W-1:0] start;
	logic [CALC_W-1:0] offset_w;
	logic [CALC_W-1:0] plen_out;
	logic              framed;
	logic              len_ok;
	logic              is_rtp;
	logic              ext_apply;
	kind_t             kind;
	logic [15:0]       seq_out;

	always_comb begin
		n_w    = CALC_W'(count_s2);
		len_w  = CALC_W'(fields_s2.len);
		pad_w  = CALC_W'(fields_s2.pad);
		ext_w  = {CALC_W'(fields_s2.ext)} << 2;
		hdr0   = CALC_W'(RTP_HDR_BASE) + (CALC_W'(fields_s2.flags[3:0]) << 2);
		framed = (fields_s2.first == magic_q) && (n_w >= CALC_W'(FRAME_HDR));
		len_ok = (len_w != '0) && (len_w + CALC_W'(FRAME_HDR) <= n_w);
		is_rtp = (len_w >= CALC_W'(RTP_HDR_BASE)) && (fields_s2.flags[7:6] == RTP_VERSION);

		plen1 = len_w;
		if (fields_s2.flags[5] && (len_w >= hdr0 + CALC_W'(1)) &&
				(pad_w != '0) && (pad_w < len_w)) begin
			plen1 = len_w - pad_w;
		end

		ext_apply = fields_s2.flags[4] && (plen1 >= hdr0 + CALC_W'(EXT_HDR)) &&
			(ext_w != '0) && (ext_w <= plen1 - hdr0 - CALC_W'(EXT_HDR));
		hdr1 = ext_apply ? (hdr0 + CALC_W'(EXT_HDR) + ext_w) : hdr0;

		if (hdr1 < plen1) begin
			start = hdr1;
			plen2 = plen1 - hdr1;
		end else begin
			start = '0;
			plen2 = plen1;
		end

		kind     = KIND_TEXT;
		seq_out  = '0;
		offset_w = '0;
		plen_out = '0;
		if (framed) begin
			if (len_ok) begin
				if (is_rtp) begin
					kind     = KIND_RTP;
					seq_out  = fields_s2.seq;
					offset_w = start + CALC_W'(FRAME_HDR);
					plen_out = plen2;
				end else begin
					kind     = KIND_RAW;
					offset_w = CALC_W'(FRAME_HDR);
					plen_out = len_w;
				end
			end else begin
				kind = KIND_DROP;
			end
		end
	end

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
		end else if (cfg_wen) begin
			magic_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && valid_s2) begin
			m_tdata_q <= {3'b000, n_w[12:0], plen_out[11:0], offset_w[11:0], seq_out};
			m_tuser_q <= {6'b000000, kind};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: rtl/rtp_datagram_header_stripper.sv
// result path: input register, header capture, output register
// throughput: one byte beat per cycle unless m_tready stalls, one result beat per datagram
// the registers stall on back-pressure; the input register stalls only on a last beat
// reset: arst_n clears all valid flags and per-datagram state, magic byte returns to 0x41
module rtp_datagram_header_stripper
	import rdhs_pkg::*;
#(
	parameter int unsigned MAX_DATAGRAM = MAX_DATAGRAM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // sequence_number, payload_offset, payload_length, datagram_length
	output logic [7:0]  m_tuser    // packet_kind
);

	localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1);

	logic             res_ready;
	logic             valid_s2;
	hdr_fields_t      fields_s2;
	logic [POS_W-1:0] count_s2;

	rdhs_capture #(
		.MAX_DATAGRAM(MAX_DATAGRAM)
	) u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.res_ready(res_ready),
		.valid_s2 (valid_s2),
		.fields_s2(fields_s2),
		.count_s2 (count_s2)
	);

	rdhs_classify #(
		.MAX_DATAGRAM(MAX_DATAGRAM)
	) u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.valid_s2 (valid_s2),
		.fields_s2(fields_s2),
		.count_s2 (count_s2),
		.res_ready(res_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
